// ===== hdl/nsr_pkg.sv =====
// Shared constants, control-word layout and microcode ROM of the Newton square root core.
// Depends on nothing; imported by nsr_div and newton_square_root_core.
package nsr_pkg;

    // Field and datapath widths
    localparam int OPERAND_WIDTH  = 32;
    localparam int FRACTION_BITS  = 16;
    localparam int ROOT_WIDTH     = 24;
    localparam int COUNT_WIDTH    = 17;
    localparam int MAXIT_WIDTH    = 17;
    localparam int TOL_WIDTH      = 16;
    localparam int SCALED_WIDTH   = OPERAND_WIDTH + FRACTION_BITS;
    localparam int PROD_WIDTH     = 2 * OPERAND_WIDTH;
    localparam int CNT_REG_WIDTH  = COUNT_WIDTH + 1;
    localparam int OUT_FIELDS     = ROOT_WIDTH + COUNT_WIDTH + 1;
    localparam int OUT_TDATA_W    = ((OUT_FIELDS + 7) / 8) * 8;
    localparam int IN_TDATA_W     = ((OPERAND_WIDTH + 7) / 8) * 8;
    localparam int CFG_DATA_WIDTH = MAXIT_WIDTH;
    localparam int CFG_IDX_WIDTH  = 2;

    // Register reset values and saturation limits
    localparam logic [MAXIT_WIDTH-1:0] MAXIT_RESET = MAXIT_WIDTH'(100000);
    localparam logic [TOL_WIDTH-1:0]   TOL_RESET   = '0;
    localparam logic [ROOT_WIDTH-1:0]  ROOT_MAX    = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_ITER = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_REL_TOL  = CFG_IDX_WIDTH'(1);

    // Microprogram addresses
    typedef logic [3:0] step_t;
    localparam step_t STEP_WAIT = 4'd0;
    localparam step_t STEP_MULB = 4'd1;
    localparam step_t STEP_SETB = 4'd2;
    localparam step_t STEP_TOP  = 4'd3;
    localparam step_t STEP_ERR  = 4'd4;
    localparam step_t STEP_CMP  = 4'd5;
    localparam step_t STEP_DIV  = 4'd6;
    localparam step_t STEP_UPD  = 4'd7;
    localparam step_t STEP_LOOP = 4'd8;
    localparam step_t STEP_DONE = 4'd9;
    localparam step_t STEP_RET  = 4'd10;

    // Jump conditions: jump to target when true, else fall through
    typedef logic [2:0] cond_t;
    localparam cond_t COND_NEVER    = 3'd0;
    localparam cond_t COND_ALWAYS   = 3'd1;
    localparam cond_t COND_NO_INPUT = 3'd2;
    localparam cond_t COND_OVER     = 3'd3;
    localparam cond_t COND_ERR_OK   = 3'd4;
    localparam cond_t COND_DIV_BUSY = 3'd5;
    localparam cond_t COND_SAME     = 3'd6;
    localparam cond_t COND_OUT_BUSY = 3'd7;

    // One control word per microprogram step
    typedef struct packed {
        cond_t cond;
        step_t target;
        logic  load;        // take the operand, seed the estimate
        logic  mul_bound;   // product <= operand * tolerance
        logic  mul_square;  // product <= estimate squared
        logic  bound_we;    // bound <= product
        logic  err_we;      // error <= |product - scaled operand|
        logic  div_start;   // scaled operand / estimate
        logic  update;      // estimate <= new estimate, count + 1
        logic  out_we;      // load the result word
    } ctrl_word_t;

    // Microcode ROM
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        w = '0;
        case (step)
            STEP_WAIT: begin
                w.load = 1'b1; w.cond = COND_NO_INPUT; w.target = STEP_WAIT;
            end
            STEP_MULB: begin
                w.mul_bound = 1'b1;
            end
            STEP_SETB: begin
                w.bound_we = 1'b1;
            end
            STEP_TOP: begin
                w.mul_square = 1'b1; w.cond = COND_OVER; w.target = STEP_DONE;
            end
            STEP_ERR: begin
                w.err_we = 1'b1;
            end
            STEP_CMP: begin
                w.div_start = 1'b1; w.cond = COND_ERR_OK; w.target = STEP_DONE;
            end
            STEP_DIV: begin
                w.cond = COND_DIV_BUSY; w.target = STEP_DIV;
            end
            STEP_UPD: begin
                w.update = 1'b1; w.cond = COND_SAME; w.target = STEP_DONE;
            end
            STEP_LOOP: begin
                w.cond = COND_ALWAYS; w.target = STEP_TOP;
            end
            STEP_DONE: begin
                w.out_we = 1'b1; w.cond = COND_OUT_BUSY; w.target = STEP_DONE;
            end
            STEP_RET: begin
                w.cond = COND_ALWAYS; w.target = STEP_WAIT;
            end
            default: begin
                w.cond = COND_ALWAYS; w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/nsr_div.sv =====
// Restoring divider, one quotient bit per cycle: scaled operand over the estimate.
// Depends on nsr_pkg for the operand and scaled widths.
module nsr_div import nsr_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [SCALED_WIDTH-1:0]  dividend,
    input  logic [OPERAND_WIDTH-1:0] divisor,
    output logic                     busy,
    output logic [SCALED_WIDTH-1:0]  quotient
);

    localparam int STEP_CNT_W = $clog2(SCALED_WIDTH + 1);
    localparam logic [STEP_CNT_W-1:0] DIV_STEPS = STEP_CNT_W'(SCALED_WIDTH);

    logic [STEP_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SCALED_WIDTH-1:0]  quo_reg, quo_next;
    logic [OPERAND_WIDTH-1:0] rem_reg, rem_next;
    logic [OPERAND_WIDTH-1:0] dsr_reg, dsr_next;
    logic [OPERAND_WIDTH:0]   rem_shift;
    logic [OPERAND_WIDTH+1:0] diff;

    // Shift in the next dividend bit, trial subtract
    assign rem_shift = {rem_reg, quo_reg[SCALED_WIDTH-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dsr_reg};

    always_comb begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start) begin
            cnt_next = DIV_STEPS;
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end else if (busy) begin
            cnt_next = cnt_reg - 1'b1;
            if (diff[OPERAND_WIDTH+1]) begin
                rem_next = rem_shift[OPERAND_WIDTH-1:0];
                quo_next = {quo_reg[SCALED_WIDTH-2:0], 1'b0};
            end else begin
                rem_next = diff[OPERAND_WIDTH-1:0];
                quo_next = {quo_reg[SCALED_WIDTH-2:0], 1'b1};
            end
        end
    end

    // Hold the step count under reset; payload needs none
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

// ===== hdl/newton_square_root_core.sv =====
// Top level of the Newton square root core: microcode sequencer, datapath and ports.
// Depends on nsr_pkg (widths, ROM) and nsr_div (shared divider).
//
//  channel | ports                         | word
//  --------+-------------------------------+------------------------------------------
//  input   | s_tvalid s_tready s_tdata     | operand
//  result  | m_tvalid m_tready m_tdata     | root, iteration_count, limit_reached
//  config  | cfg_valid cfg_ready cfg_index | 0 max_iterations, 1 relative_tolerance
//          | cfg_data                      |
//
// One operand at a time. Setup accepts the operand and forms the tolerance bound; each
// Newton step squares the estimate, checks the error, then waits on the bit-serial divider,
// which yields all 48 quotient bits, and updates the estimate. A zero operand or a tolerance
// hit before the first step goes straight to the result. The reset limit is 100000 steps.
// Reset (aresetn low, synchronous) returns the sequencer to its wait step and loads
// the register defaults. A result stalled by m_tready holds the sequencer in its
// final step; the next operand is taken once the result word sits in the
// output register, even while it still waits there.
module newton_square_root_core import nsr_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_W-1:0]     s_tdata,   // [31:0] operand
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_W-1:0]    m_tdata,   // [23:0] root, [40:24] iteration_count,
                                                 // [41] limit_reached, rest zero
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    ctrl_word_t cw;

    logic [3:0]               step_reg, step_next;
    logic [MAXIT_WIDTH-1:0]   maxit_reg;
    logic [TOL_WIDTH-1:0]     tol_reg;
    logic [OPERAND_WIDTH-1:0] x_reg;
    logic [OPERAND_WIDTH-1:0] t_reg, t_next;
    logic [CNT_REG_WIDTH-1:0] cnt_reg;
    logic [PROD_WIDTH-1:0]    prod_reg;
    logic [SCALED_WIDTH-1:0]  bound_reg;
    logic [PROD_WIDTH-1:0]    err_reg;
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;

    logic                     in_accept;
    logic                     out_busy;
    logic                     cond_true;
    logic [SCALED_WIDTH-1:0]  xs;
    logic [PROD_WIDTH-1:0]    xs_wide;
    logic [OPERAND_WIDTH-1:0] mul_a, mul_b;
    logic                     div_busy;
    logic [SCALED_WIDTH-1:0]  quotient;
    logic [SCALED_WIDTH-1:0]  nt_sum;
    logic                     nt_same;
    logic                     over_limit;
    logic [ROOT_WIDTH-1:0]    root_sat;
    logic [COUNT_WIDTH-1:0]   count_sat;

    // Fetch the control word of the current step
    assign cw        = ucode_rom(step_reg);
    assign s_tready  = (step_reg == STEP_WAIT);
    assign in_accept = s_tvalid && s_tready;
    assign out_busy  = m_tvalid_reg && !m_tready;
    assign cfg_ready = 1'b1;

    assign xs      = {x_reg, {FRACTION_BITS{1'b0}}};
    assign xs_wide = {{(PROD_WIDTH-SCALED_WIDTH){1'b0}}, xs};

    // New estimate: floor((q + t) / 2) without the carry-out
    assign nt_sum  = {1'b0, quotient[SCALED_WIDTH-1:1]}
                   + {{(SCALED_WIDTH-OPERAND_WIDTH+1){1'b0}}, t_reg[OPERAND_WIDTH-1:1]}
                   + {{(SCALED_WIDTH-1){1'b0}}, quotient[0] & t_reg[0]};
    assign nt_same = (nt_sum == {{(SCALED_WIDTH-OPERAND_WIDTH){1'b0}}, t_reg});
    assign t_next  = nt_sum[OPERAND_WIDTH-1:0];

    assign over_limit = (cnt_reg > {1'b0, maxit_reg});

    // Evaluate the jump condition
    always_comb begin
        case (cw.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_NO_INPUT: cond_true = !s_tvalid;
            COND_OVER:     cond_true = over_limit;
            COND_ERR_OK:   cond_true = (err_reg <= {{(PROD_WIDTH-SCALED_WIDTH){1'b0}}, bound_reg});
            COND_DIV_BUSY: cond_true = div_busy;
            COND_SAME:     cond_true = nt_same;
            COND_OUT_BUSY: cond_true = out_busy;
            default:       cond_true = 1'b0;
        endcase
    end

    assign step_next = cond_true ? cw.target : step_reg + 1'b1;

    // Select multiplier operands: tolerance bound or estimate squared
    assign mul_a = cw.mul_square ? t_reg : x_reg;
    assign mul_b = cw.mul_square ? t_reg
                                 : {{(OPERAND_WIDTH-TOL_WIDTH){1'b0}}, tol_reg};

    // Shared divider
    nsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cw.div_start && !cond_true),
        .dividend (xs),
        .divisor  (t_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Saturate the result fields
    assign root_sat  = (t_reg > {{(OPERAND_WIDTH-ROOT_WIDTH){1'b0}}, ROOT_MAX})
                     ? ROOT_MAX : t_reg[ROOT_WIDTH-1:0];
    assign count_sat = cnt_reg[COUNT_WIDTH] ? COUNT_MAX : cnt_reg[COUNT_WIDTH-1:0];

    // Control state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= STEP_WAIT;
            maxit_reg    <= MAXIT_RESET;
            tol_reg      <= TOL_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAX_ITER: maxit_reg <= cfg_data;
                    CFG_REL_TOL:  tol_reg   <= cfg_data[TOL_WIDTH-1:0];
                    default:      ;
                endcase
            end
            if (cw.out_we && !out_busy) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (cw.load && in_accept) begin
            x_reg   <= s_tdata[OPERAND_WIDTH-1:0];
            t_reg   <= s_tdata[OPERAND_WIDTH-1:0];
            cnt_reg <= '0;
        end else if (cw.update) begin
            t_reg   <= t_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cw.mul_bound || cw.mul_square) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cw.bound_we) begin
            bound_reg <= prod_reg[SCALED_WIDTH-1:0];
        end
        if (cw.err_we) begin
            err_reg <= (prod_reg > xs_wide) ? prod_reg - xs_wide : xs_wide - prod_reg;
        end
        if (cw.out_we && !out_busy) begin
            m_tdata_reg <= {{(OUT_TDATA_W-OUT_FIELDS){1'b0}}, over_limit, count_sat, root_sat};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for newton_square_root_core: a directed table, then random operands,
// every result word compared with a bit-exact Newton predictor. Depends on nsr_pkg and the RTL.
module tb_top;
    import nsr_pkg::*;

    localparam int LIMIT_CYCLES  = 8_000_000;
    localparam int STEP_CAP      = 40;      // random operands needing more steps are redrawn
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 64;
    localparam int HOLD_CYCLES   = 4000;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 50;

    // Register indexes the core does not decode
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_2 = CFG_IDX_WIDTH'(2);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_3 = CFG_IDX_WIDTH'(3);

    // Same bit order as the low bits of m_tdata
    typedef struct packed {
        logic                   limit_reached;
        logic [COUNT_WIDTH-1:0] iteration_count;
        logic [ROOT_WIDTH-1:0]  root;
    } sqrt_result_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_OPERAND, ROW_TYPED} row_kind_e;
    typedef enum logic [1:0] {SINK_OPEN, SINK_HALF, SINK_SPARSE} sink_mode_e;

    typedef struct {
        row_kind_e                kind;
        logic [CFG_IDX_WIDTH-1:0] index;
        logic [31:0]              value;
        sqrt_result_t             result;
    } dir_row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_TDATA_W-1:0]     s_tdata;     // [31:0] operand
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_W-1:0]    m_tdata;     // [23:0] root, [40:24] iteration_count,
                                            // [41] limit_reached
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    // Predictor copy of the two registers
    logic [MAXIT_WIDTH-1:0] iter_limit;
    logic [TOL_WIDTH-1:0]   rel_tol;

    sqrt_result_t pending_roots[$];
    dir_row_t     dir_rows[$];
    int           mismatch_count = 0;
    int           results_seen   = 0;
    int           burst_left;
    longint       cycle_count    = 0;

    newton_square_root_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Heron iteration on Q16.16 integers, squares saturating at 64 bits
    function automatic sqrt_result_t predict_root(input logic [OPERAND_WIDTH-1:0] operand);
        logic [63:0]  scaled, bound, est, sq, err, quot, next_est;
        logic [127:0] prod;
        logic [31:0]  steps;
        bit           done;
        sqrt_result_t res;
        scaled = 64'(operand) << FRACTION_BITS;
        bound  = 64'(operand) * 64'(rel_tol);
        est    = 64'(operand);
        steps  = 0;
        done   = 1'b0;
        while (!done && steps <= 32'(iter_limit)) begin
            prod = 128'(est) * 128'(est);
            sq   = (prod[127:64] != 0) ? '1 : prod[63:0];
            err  = (sq > scaled) ? sq - scaled : scaled - sq;
            if (err <= bound) begin
                done = 1'b1;
            end else begin
                quot     = (est == 0) ? '1 : scaled / est;
                next_est = (quot >> 1) + (est >> 1) + (quot & est & 64'd1);
                steps++;
                if (next_est == est)
                    done = 1'b1;
                else
                    est = next_est;
            end
        end
        res.root            = (est > 64'(ROOT_MAX)) ? ROOT_MAX : est[ROOT_WIDTH-1:0];
        res.iteration_count = (steps > 32'(COUNT_MAX)) ? COUNT_MAX : steps[COUNT_WIDTH-1:0];
        res.limit_reached   = (steps > 32'(iter_limit));
        return res;
    endfunction

    // Random operand from a mix of plain, small, exact-square, alternating, near-full and corner values (0, 1, 1.0)
    function automatic logic [OPERAND_WIDTH-1:0] pick_operand();
        logic [63:0] k;
        logic [31:0] j;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return $urandom;
        if (sel < 65)
            return $urandom_range(0, 65535);
        if (sel < 80) begin
            j = $urandom_range(1, 65535);
            return j * j;
        end
        if (sel < 88) begin
            // scaled operand one below an odd square: estimate alternates at the end
            k = 64'($urandom_range(1, 511)) * 64'd32768;
            k = $urandom_range(0, 1) ? k + 64'd1 : k - 64'd1;
            return 32'((k * k - 64'd1) >> FRACTION_BITS);
        end
        if (sel < 94)
            return 32'hFFFF_FFFF - $urandom_range(0, 255);
        case ($urandom_range(0, 2))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic void add_write(input logic [CFG_IDX_WIDTH-1:0] index,
                                      input logic [31:0] data);
        dir_row_t row;
        row.kind   = ROW_WRITE;
        row.index  = index;
        row.value  = data;
        row.result = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_operand(input logic [31:0] operand);
        dir_row_t row;
        row.kind   = ROW_OPERAND;
        row.index  = CFG_MAX_ITER;
        row.value  = operand;
        row.result = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(input logic [31:0] operand,
                                      input logic [ROOT_WIDTH-1:0] root,
                                      input logic [COUNT_WIDTH-1:0] count,
                                      input logic limit);
        dir_row_t row;
        row.kind                   = ROW_TYPED;
        row.index                  = CFG_MAX_ITER;
        row.value                  = operand;
        row.result.root            = root;
        row.result.iteration_count = count;
        row.result.limit_reached   = limit;
        dir_rows.push_back(row);
    endfunction

    // Offer one operand in the current burst; return at the falling edge after the word,
    // with s_tvalid still high so a following word can go out back to back
    task automatic offer_operand(input logic [OPERAND_WIDTH-1:0] operand,
                                 input sqrt_result_t want);
        int unsigned gap;
        int unsigned pick;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                gap = 0;
            else if (pick == 3)
                gap = $urandom_range(100, 1200);
            else
                gap = $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(operand);
        do @(posedge aclk); while (!s_tready);
        pending_roots.push_back(want);
        burst_left--;
        @(negedge aclk);
    endtask

    // Write a register once the core has drained
    task automatic write_register(input logic [CFG_IDX_WIDTH-1:0] index,
                                  input logic [CFG_DATA_WIDTH-1:0] data);
        s_tvalid <= 1'b0;
        while (pending_roots.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            CFG_MAX_ITER: iter_limit = data;
            CFG_REL_TOL:  rel_tol = data[TOL_WIDTH-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: stall pattern of its own, plus long hold-offs to back the core up
    initial begin : result_sink
        int         hold_left;
        int         mode_left;
        int         next_hold;
        sink_mode_e mode;
        hold_left = 0;
        mode_left = 200;
        next_hold = 60;
        mode      = SINK_OPEN;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && results_seen >= next_hold && next_hold <= 210) begin
                hold_left = HOLD_CYCLES;
                next_hold += 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    SINK_OPEN: m_tready <= 1'b1;
                    SINK_HALF: m_tready <= 1'($urandom_range(0, 1));
                    default:   m_tready <= ($urandom_range(0, 7) == 0);
                endcase
                mode_left--;
                if (mode_left == 0) begin
                    mode      = sink_mode_e'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 600);
                end
            end
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge aclk) begin : check_results
        sqrt_result_t got;
        sqrt_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[OUT_FIELDS-1:0];
            results_seen++;
            if (pending_roots.size() == 0) begin
                $display("%0t: result word %h with nothing expected", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_roots.pop_front();
                if (got.root !== want.root) begin
                    $display("%0t: root expected %h actual %h", $time, want.root, got.root);
                    mismatch_count++;
                end
                if (got.iteration_count !== want.iteration_count) begin
                    $display("%0t: iteration_count expected %0d actual %0d", $time,
                             want.iteration_count, got.iteration_count);
                    mismatch_count++;
                end
                if (got.limit_reached !== want.limit_reached) begin
                    $display("%0t: limit_reached expected %b actual %b", $time,
                             want.limit_reached, got.limit_reached);
                    mismatch_count++;
                end
                if (m_tdata[OUT_TDATA_W-1:OUT_FIELDS] !== '0) begin
                    $display("%0t: tdata padding expected 0 actual %h", $time,
                             m_tdata[OUT_TDATA_W-1:OUT_FIELDS]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [OPERAND_WIDTH-1:0]  operand;
        logic [CFG_DATA_WIDTH-1:0] limit_word;
        logic [CFG_DATA_WIDTH-1:0] tol_word;
        sqrt_result_t              want;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_MAX_ITER;
        cfg_data   = '0;
        iter_limit = MAXIT_RESET;
        rel_tol    = TOL_RESET;
        burst_left = 0;

        // Reset settings: limit 100000, no tolerance
        add_typed(32'h0000_0000, 24'h00_0000, 17'd0, 1'b0);    // zero operand returns at once
        add_typed(32'h0001_0000, 24'h01_0000, 17'd0, 1'b0);    // 1.0 is its own root
        add_operand(32'h0000_0001);
        add_operand(32'h0000_0002);
        add_operand(32'h0004_0000);                        // exact square met inside the loop
        add_operand(32'h8000_0000);
        add_operand(32'h5555_5555);
        add_operand(32'hAAAA_AAAA);
        add_operand(32'hFFFF_FFFF);
        // Limit at its floor: one step, then the limit flag
        add_write(CFG_MAX_ITER, 32'd0);
        add_typed(32'h0000_0001, 24'h00_8000, 17'd1, 1'b1);
        add_typed(32'hFFFF_FFFF, ROOT_MAX, 17'd1, 1'b1);       // root too wide, saturates
        add_typed(32'h0000_0000, 24'h00_0000, 17'd0, 1'b0);
        add_typed(32'h0001_0000, 24'h01_0000, 17'd0, 1'b0);
        // Estimates alternating between two values run into the limit
        add_write(CFG_MAX_ITER, 32'd5);
        add_operand(32'd16383);
        add_operand(32'd16385);
        add_operand(32'd65534);
        // Widest limit and widest tolerance
        add_write(CFG_MAX_ITER, 32'h0001_FFFF);
        add_write(CFG_REL_TOL, 32'h0000_FFFF);
        add_typed(32'd100, 24'd100, 17'd0, 1'b0);
        add_operand(32'h0001_FFFF);
        add_operand(32'hFFFF_FFFF);
        // Unknown register indexes leave both registers alone
        add_write(CFG_SPARE_2, 32'h0000_0000);
        add_write(CFG_SPARE_3, 32'h0001_FFFF);
        add_typed(32'd100, 24'd100, 17'd0, 1'b0);
        // Tolerance keeps only its low 16 bits
        add_write(CFG_REL_TOL, 32'h0001_0000);
        add_operand(32'h0002_0000);

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(negedge aclk);

        // Walk the directed table
        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_WRITE: write_register(dir_rows[i].index,
                                          dir_rows[i].value[CFG_DATA_WIDTH-1:0]);
                ROW_TYPED: offer_operand(dir_rows[i].value, dir_rows[i].result);
                default:   offer_operand(dir_rows[i].value, predict_root(dir_rows[i].value));
            endcase
        end

        // Random phases, each with fresh register settings
        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       limit_word = '0;
                1:       limit_word = CFG_DATA_WIDTH'($urandom_range(1, 8));
                2:       limit_word = CFG_DATA_WIDTH'($urandom_range(9, 40));
                3:       limit_word = MAXIT_RESET;
                4:       limit_word = '1;
                default: limit_word = CFG_DATA_WIDTH'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       tol_word = '0;
                1:       tol_word = CFG_DATA_WIDTH'(17'h0FFFF);
                2:       tol_word = CFG_DATA_WIDTH'($urandom_range(1, 64));
                3:       tol_word = CFG_DATA_WIDTH'($urandom);
                default: tol_word = CFG_DATA_WIDTH'($urandom_range(0, 4095));
            endcase
            if ($urandom_range(0, 1)) begin
                write_register(CFG_MAX_ITER, limit_word);
                write_register(CFG_REL_TOL, tol_word);
            end else begin
                write_register(CFG_REL_TOL, tol_word);
                write_register(CFG_MAX_ITER, limit_word);
            end
            if ($urandom_range(0, 3) == 0)
                write_register($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                               CFG_DATA_WIDTH'($urandom));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // redraw operands that would keep the core iterating for long
                do begin
                    operand = pick_operand();
                    want    = predict_root(operand);
                end while (want.iteration_count > STEP_CAP);
                offer_operand(operand, want);
            end
        end

        // Drain and report
        s_tvalid <= 1'b0;
        while (pending_roots.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
